/* hw/rtl/arlp_pkg.sv */
// shared types, constants and reply patterns for the modem reply line parser
// no dependencies; imported by every module of the block
package arlp_pkg;

    localparam int LINE_DEPTH = 256;
    localparam int POS_W      = $clog2(LINE_DEPTH);
    localparam int HEAD_LEN   = 18;
    localparam int HEAD_IDX_W = $clog2(HEAD_LEN);
    localparam int TAIL_LEN   = 7;

    localparam logic [2:0] STEP_DONE = 3'd6;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_THREE = 8'd51;
    localparam logic [7:0] CH_O     = 8'd79;
    localparam logic [7:0] CH_K     = 8'd75;
    localparam logic [7:0] CH_E     = 8'd69;
    localparam logic [7:0] CH_R     = 8'd82;

    localparam logic [0:7][7:0] PAT_CONNECT =
        {8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43, 8'h54, 8'h0D};
    localparam logic [0:6][7:0] PAT_IPD_CRLF =
        {8'h0D, 8'h0A, 8'h2B, 8'h49, 8'h50, 8'h44, 8'h2C};
    localparam logic [0:4][7:0] PAT_IPD =
        {8'h2B, 8'h49, 8'h50, 8'h44, 8'h2C};

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_RESTART = 2'd1,
        OP_REISSUE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_OK    = 3'd1,
        EV_ERROR = 3'd2,
        EV_CONN  = 3'd3,
        EV_DATA  = 3'd4,
        EV_UNREC = 3'd5
    } ev_t;

    // line contents with the current byte already written in
    typedef struct packed {
        logic [POS_W-1:0]               pos;
        logic [HEAD_LEN-1:0][7:0]       head;
        logic [TAIL_LEN-1:0][7:0]       tail;
    } line_view_t;

    typedef struct packed {
        ev_t        ev;
        logic       close;
        logic       conn_set;
        logic [1:0] conn_chan;
        logic [7:0] chan;
        logic [15:0] len;
    } line_class_t;

endpackage

/* hw/rtl/arlp_line_buffer.sv */
// line storage: write position, first line bytes and the newest-first tail window
// depends on arlp_pkg
module arlp_line_buffer
    import arlp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_en,
    input  logic [7:0] rx_byte,
    input  logic       line_close,
    output line_view_t view
);

    logic [POS_W-1:0]         pos_reg;
    logic [POS_W-1:0]         pos_next;
    logic [HEAD_LEN-1:0][7:0] head_reg;
    logic [HEAD_LEN-1:0][7:0] head_next;
    logic [TAIL_LEN-1:0][7:0] tail_reg;
    logic [TAIL_LEN-1:0][7:0] tail_next;

    always_comb begin
        for (int k = 0; k < HEAD_LEN; k++) begin
            head_next[k] = (pos_reg == POS_W'(k)) ? rx_byte : head_reg[k];
        end
        tail_next[0] = rx_byte;
        for (int i = 1; i < TAIL_LEN; i++) begin
            tail_next[i] = tail_reg[i-1];
        end
        pos_next = line_close ? '0 : pos_reg + POS_W'(1);
    end

    assign view.pos  = pos_reg;
    assign view.head = head_next;
    assign view.tail = tail_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            head_reg <= '0;
            tail_reg <= '0;
        end else if (byte_en) begin
            pos_reg  <= pos_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

endmodule

/* hw/rtl/arlp_line_classify.sv */
// line end detection, reply classification and data header decode
// depends on arlp_pkg; purely combinational
module arlp_line_classify
    import arlp_pkg::*;
(
    input  line_view_t  view,
    output line_class_t res
);

    logic        crlf;
    logic [7:0]  h0;
    logic        has_ipd_crlf;
    logic        has_ipd;
    logic        has_connect;
    ev_t         ev;
    logic [3:0]  mark;
    logic [HEAD_IDX_W-1:0] mark2;
    logic [2:0]  flag;
    logic [HEAD_IDX_W-1:0] stop;
    logic [1:0]  ndig;
    logic [15:0] d1;
    logic [15:0] d2;
    logic [15:0] d3;
    logic [15:0] sum;
    logic [7:0]  chan;

    always_comb begin
        crlf = (view.tail[1] == CH_CR) && (view.tail[0] == CH_LF);
        h0   = view.head[0];

        has_ipd_crlf = 1'b1;
        for (int i = 0; i < 7; i++) begin
            if (view.head[i] != PAT_IPD_CRLF[i]) has_ipd_crlf = 1'b0;
        end
        has_ipd = 1'b1;
        for (int i = 0; i < 5; i++) begin
            if (view.head[i] != PAT_IPD[i]) has_ipd = 1'b0;
        end
        has_connect = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (view.head[i+2] != PAT_CONNECT[i]) has_connect = 1'b0;
        end

        ev = EV_NONE;
        if (view.pos >= POS_W'(3)) begin
            if (crlf && view.tail[3] == CH_O && view.tail[2] == CH_K) begin
                ev = EV_OK;
            end else if (crlf && view.pos >= POS_W'(6) && view.tail[6] == CH_E &&
                         view.tail[5] == CH_R && view.tail[4] == CH_R &&
                         view.tail[3] == CH_O && view.tail[2] == CH_R) begin
                ev = EV_ERROR;
            end else if (h0 >= CH_ZERO && h0 <= CH_THREE) begin
                // channel lines only close with a comma after the channel digit
                if (crlf && view.head[1] == CH_COMMA) ev = EV_CONN;
            end else if (crlf && (has_ipd_crlf || has_ipd)) begin
                ev = EV_DATA;
            end else if (crlf) begin
                ev = EV_UNREC;
            end
        end
        // overflow discards the unclosed line
        if (ev == EV_NONE && view.pos == POS_W'(LINE_DEPTH - 1)) begin
            ev = EV_UNREC;
        end

        // first comma in places 0..9, else stop at 10
        mark = 4'd10;
        for (int m = 9; m >= 0; m--) begin
            if (view.head[m] == CH_COMMA) mark = 4'(m);
        end
        chan  = view.head[HEAD_IDX_W'(mark) + HEAD_IDX_W'(1)] - CH_ZERO;
        mark2 = HEAD_IDX_W'(mark) + HEAD_IDX_W'(2);

        // colon within four places after the channel, else stop at five
        flag = 3'd5;
        for (int f = 4; f >= 1; f--) begin
            if (view.head[mark2 + HEAD_IDX_W'(f)] == CH_COLON) flag = 3'(f);
        end
        stop = mark2 + HEAD_IDX_W'(flag);
        ndig = (flag > 3'd3) ? 2'd3 : 2'(flag - 3'd1);

        d1 = {8'd0, view.head[stop - HEAD_IDX_W'(1)]} - {8'd0, CH_ZERO};
        d2 = {8'd0, view.head[stop - HEAD_IDX_W'(2)]} - {8'd0, CH_ZERO};
        d3 = {8'd0, view.head[stop - HEAD_IDX_W'(3)]} - {8'd0, CH_ZERO};
        sum = '0;
        if (ndig >= 2'd1) sum = sum + d1;
        if (ndig >= 2'd2) sum = sum + (d2 << 3) + (d2 << 1);
        if (ndig >= 2'd3) sum = sum + (d3 << 6) + (d3 << 5) + (d3 << 2);

        res.ev        = ev;
        res.close     = (ev != EV_NONE);
        res.conn_set  = has_connect;
        res.conn_chan = h0[1:0];
        res.chan      = (ev == EV_DATA) ? chan : 8'd0;
        res.len       = (ev == EV_DATA) ? sum : 16'd0;
    end

endmodule

/* hw/rtl/at_response_line_parser_unit.sv */
// Modem reply line parser: takes one reply byte or setup command per transaction and returns
// one result per transaction. Throughput is one transaction per cycle unless m_ready stalls;
// a transaction passes the input register, the combinational classifier and the result register.
// A stall on m_ready holds the result and a full input register, which keeps s_ready low.
// depends on arlp_pkg, arlp_line_buffer and arlp_line_classify
module at_response_line_parser_unit
    import arlp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [2:0]  m_setup_now,
    output logic        m_issue_command,
    output logic [2:0]  m_command_index,
    output logic [3:0]  m_connected_mask,
    output logic [7:0]  m_data_channel,
    output logic [15:0] m_data_length
);

    logic        in_valid_reg;
    logic [1:0]  in_op_reg;
    logic [7:0]  in_byte_reg;
    logic        advance;
    logic        byte_en;

    line_view_t  view;
    line_class_t cls;

    logic [2:0]  step_reg;
    logic [2:0]  step_next;
    logic [3:0]  mask_reg;
    logic [3:0]  mask_next;
    ev_t         ev;
    logic        issue;
    logic [2:0]  idx;
    logic [3:0]  bit_sel;

    logic        out_valid_reg;
    logic [2:0]  out_ev_reg;
    logic        out_issue_reg;
    logic [2:0]  out_idx_reg;
    logic [7:0]  out_chan_reg;
    logic [15:0] out_len_reg;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign byte_en = advance && (op_t'(in_op_reg) == OP_BYTE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg   <= s_opcode;
            in_byte_reg <= s_rx_byte;
        end
    end

    arlp_line_buffer u_line_buffer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_en    (byte_en),
        .rx_byte    (in_byte_reg),
        .line_close (cls.close),
        .view       (view)
    );

    arlp_line_classify u_line_classify (
        .view (view),
        .res  (cls)
    );

    // setup sequencer and channel mask
    always_comb begin
        step_next = step_reg;
        mask_next = mask_reg;
        ev        = EV_NONE;
        issue     = 1'b0;
        idx       = 3'd0;
        bit_sel   = 4'b0001 << cls.conn_chan;
        case (op_t'(in_op_reg))
            OP_RESTART: begin
                step_next = 3'd0;
                issue     = 1'b1;
            end
            OP_REISSUE: begin
                if (step_reg < STEP_DONE) begin
                    issue = 1'b1;
                    idx   = step_reg;
                end
            end
            OP_BYTE: begin
                ev = cls.ev;
                if (cls.ev == EV_OK && step_reg < STEP_DONE) begin
                    step_next = step_reg + 3'd1;
                    if (step_next < STEP_DONE) begin
                        issue = 1'b1;
                        idx   = step_next;
                    end
                end else if (cls.ev == EV_CONN) begin
                    mask_next = cls.conn_set ? (mask_reg | bit_sel) : (mask_reg & ~bit_sel);
                end
            end
            default: begin
                ev = EV_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= 3'd0;
            mask_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                step_reg <= step_next;
                mask_reg <= mask_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_ev_reg    <= ev;
            out_issue_reg <= issue;
            out_idx_reg   <= idx;
            out_chan_reg  <= (ev == EV_DATA) ? cls.chan : 8'd0;
            out_len_reg   <= (ev == EV_DATA) ? cls.len : 16'd0;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_event_res      = out_ev_reg;
    assign m_setup_now      = step_reg;
    assign m_issue_command  = out_issue_reg;
    assign m_command_index  = out_idx_reg;
    assign m_connected_mask = mask_reg;
    assign m_data_channel   = out_chan_reg;
    assign m_data_length    = out_len_reg;

    // setup step never passes the completion value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_setup_now <= STEP_DONE)
        else $error("setup step out of range");

    // command index is zero when no command is requested
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_issue_command |-> m_command_index == 3'd0)
        else $error("command index without request");

    // data fields only carry values on data headers
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res != EV_DATA |-> m_data_channel == 8'd0 && m_data_length == 16'd0)
        else $error("data fields set outside data header");

    // an OK that requests a command names the step just reached
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_OK && m_issue_command |-> m_command_index == m_setup_now)
        else $error("command index does not follow setup step");

    // a closed line restarts at position zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        byte_en && cls.close |=> view.pos == '0)
        else $error("line position not cleared after line end");

endmodule
